### rtl/ulkt_pkg.sv
// Shared types, codes and keyword tables for the status line keyword tracker.
`default_nettype none

package ulkt_pkg;

    localparam int KW_COUNT = 6;
    localparam int KW_MAX   = 10;

    // Keyword order in the seen mask
    localparam int KW_POWER_ON   = 0;
    localparam int KW_DISCONNECT = 1;
    localparam int KW_STATUS0    = 2;
    localparam int KW_CONNECT    = 3;
    localparam int KW_STATUS1    = 4;
    localparam int KW_SCAN       = 5;

    localparam logic [1:0] OP_RX_BYTE   = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_POWER_OFF = 2'd2;

    localparam logic [1:0] LINK_UNKNOWN = 2'd0;
    localparam logic [1:0] LINK_DOWN    = 2'd1;
    localparam logic [1:0] LINK_UP      = 2'd2;
    localparam logic [1:0] LINK_SCAN    = 2'd3;

    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_STATUS    = 2'd1;
    localparam logic [1:0] CMD_POWER_OFF = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_PRINTABLE = 8'h20;

    localparam logic [21:0] POLL_PERIOD_RESET = 22'd60000;

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd8, 4'd10, 4'd8, 4'd7, 4'd8, 4'd4};

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
        '{"P", "O", "W", "E", "R", " ", "O", "N", 8'h00, 8'h00},
        '{"D", "I", "S", "C", "O", "N", "N", "E", "C", "T"},
        '{"S", "T", "A", "T", "U", "S", ":", "0", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "T", "U", "S", ":", "1", 8'h00, 8'h00},
        '{"S", "C", "A", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
        logic        poll_enabled;
    } item_t;

    typedef struct packed {
        logic                ended;
        logic [KW_COUNT-1:0] seen;
    } line_evt_t;

    typedef struct packed {
        logic [1:0] link_state;
        logic       powered;
        logic       soft_off;
        logic       line_ended;
        logic [1:0] send_command;
    } res_t;

    // Longest keyword prefix that is a suffix of the matched prefix plus the byte
    function automatic logic [3:0] kw_advance(input int k, input logic [3:0] p,
                                              input logic [7:0] c);
        logic [3:0] q;
        logic [3:0] res;
        logic [3:0] idx;
        logic       ok;
        q   = (p >= KW_LEN[k]) ? 4'd0 : p;
        res = 4'd0;
        for (int n = 1; n <= KW_MAX; n++)
        begin
            if (n <= int'(KW_LEN[k]) && n <= int'(q) + 1)
            begin
                ok = (KW_TEXT[k][n-1] == c);
                for (int i = 0; i < n - 1; i++)
                begin
                    idx = 4'(int'(q) - (n - 1) + i);
                    if (KW_TEXT[k][idx] != KW_TEXT[k][i])
                        ok = 1'b0;
                end
                if (ok)
                    res = 4'(n);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ulkt_line_tracker.sv
// Line assembler with per-keyword incremental matchers.
`default_nettype none

module ulkt_line_tracker
    import ulkt_pkg::*;
#(
    parameter int LINE_BYTES = 128
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire item_t     item,
    output line_evt_t      evt
);

    localparam int LEN_W = $clog2(LINE_BYTES);

    logic [LEN_W-1:0]    line_length_reg, line_length_next;
    logic [3:0]          progress_reg [KW_COUNT];
    logic [3:0]          progress_next [KW_COUNT];
    logic [3:0]          adv [KW_COUNT];
    logic [KW_COUNT-1:0] seen_reg, seen_next;
    logic                is_byte;
    logic                keep;
    logic                ended;

    genvar g;
    generate
        for (g = 0; g < KW_COUNT; g++)
        begin : g_kw
            assign adv[g] = kw_advance(g, progress_reg[g], item.rx_byte);
        end
    endgenerate

    assign is_byte = fire && (item.op == OP_RX_BYTE);
    assign ended   = is_byte && (item.rx_byte == CHAR_NEWLINE) && (line_length_reg != '0);
    assign keep    = is_byte && (item.rx_byte >= CHAR_PRINTABLE)
                     && (line_length_reg < LEN_W'(LINE_BYTES - 1));

    always_comb
    begin
        line_length_next = line_length_reg;
        seen_next        = seen_reg;
        for (int k = 0; k < KW_COUNT; k++)
            progress_next[k] = progress_reg[k];
        if (ended)
        begin
            line_length_next = '0;
            seen_next        = '0;
            for (int k = 0; k < KW_COUNT; k++)
                progress_next[k] = 4'd0;
        end
        else if (keep)
        begin
            line_length_next = line_length_reg + 1'b1;
            for (int k = 0; k < KW_COUNT; k++)
            begin
                // Restart the matcher after a full hit
                if (adv[k] == KW_LEN[k])
                begin
                    seen_next[k]     = 1'b1;
                    progress_next[k] = 4'd0;
                end
                else
                    progress_next[k] = adv[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= '0;
            seen_reg        <= '0;
            for (int k = 0; k < KW_COUNT; k++)
                progress_reg[k] <= 4'd0;
        end
        else
        begin
            line_length_reg <= line_length_next;
            seen_reg        <= seen_next;
            for (int k = 0; k < KW_COUNT; k++)
                progress_reg[k] <= progress_next[k];
        end
    end

    assign evt.ended = ended;
    assign evt.seen  = seen_reg;

endmodule

`default_nettype wire

### rtl/ulkt_link_ctrl.sv
// Power, soft-off and link state, poll timer and command selection.
`default_nettype none

module ulkt_link_ctrl
    import ulkt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [21:0] cfg_data,
    input  wire logic        fire,
    input  wire item_t       item,
    input  wire line_evt_t   evt,
    output res_t             res
);

    logic [21:0] period_reg;
    logic [1:0]  link_reg, link_next;
    logic        power_reg, power_next;
    logic        off_reg, off_next;
    logic [31:0] next_poll_reg, next_poll_next;
    logic [31:0] poll_sum;
    logic [31:0] poll_diff;
    logic        gated;
    logic [1:0]  cmd;

    assign poll_sum  = item.now_ms + {10'd0, period_reg};
    assign poll_diff = item.now_ms - next_poll_reg;
    assign gated     = !item.poll_enabled || !power_reg || off_reg || (link_reg == LINK_UP);

    always_comb
    begin
        link_next      = link_reg;
        power_next     = power_reg;
        off_next       = off_reg;
        next_poll_next = next_poll_reg;
        cmd            = CMD_NONE;
        if (fire)
        begin
            case (item.op)
                OP_RX_BYTE:
                begin
                    if (evt.ended)
                    begin
                        if (evt.seen[KW_POWER_ON])
                        begin
                            power_next = 1'b1;
                            off_next   = 1'b0;
                            link_next  = LINK_UNKNOWN;
                        end
                        if (evt.seen[KW_DISCONNECT] || evt.seen[KW_STATUS0])
                            link_next = LINK_DOWN;
                        else if (evt.seen[KW_CONNECT] || evt.seen[KW_STATUS1])
                            link_next = LINK_UP;
                        else if (evt.seen[KW_SCAN])
                            link_next = LINK_SCAN;
                    end
                end
                OP_TICK:
                begin
                    // Wrapping compare: due once now is not behind the poll time
                    if (gated)
                        next_poll_next = poll_sum;
                    else if (!poll_diff[31])
                    begin
                        next_poll_next = poll_sum;
                        cmd            = CMD_STATUS;
                    end
                end
                OP_POWER_OFF:
                begin
                    cmd       = CMD_POWER_OFF;
                    off_next  = 1'b1;
                    link_next = LINK_DOWN;
                end
                default:
                begin
                    cmd = CMD_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= POLL_PERIOD_RESET;
            link_reg      <= LINK_UNKNOWN;
            power_reg     <= 1'b0;
            off_reg       <= 1'b0;
            next_poll_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                period_reg <= cfg_data;
            link_reg      <= link_next;
            power_reg     <= power_next;
            off_reg       <= off_next;
            next_poll_reg <= next_poll_next;
        end
    end

    assign res.link_state   = link_next;
    assign res.powered      = power_next;
    assign res.soft_off     = off_next;
    assign res.line_ended   = evt.ended;
    assign res.send_command = cmd;

endmodule

`default_nettype wire

### rtl/uart_status_line_keyword_tracker_core.sv
// Top level: input register, line tracker, link control and result register.
// A word taken into the input register is processed and loaded into the result
// register once the result register is empty or being taken.
// Throughput: one word per cycle; the input register and result register advance
// together whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous) clears all flags, matchers, the poll time and
// loads the poll period with 60000; no clearing pass follows.
`default_nettype none

module uart_status_line_keyword_tracker_core
    import ulkt_pkg::*;
#(
    parameter int LINE_BYTES = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // rx_byte[7:0], now_ms[39:8], poll_enabled[40]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // link_state[1:0], powered[2], soft_off[3],
                                        // send_command[5:4]
    output logic             m_tlast,   // line_ended
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [21:0] cfg_data
);

    logic      in_valid_reg;
    item_t     in_item_reg;
    logic      res_valid_reg;
    res_t      res_reg;
    logic      advance;
    logic      fire;
    line_evt_t evt;
    res_t      res;

    assign advance   = !res_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ulkt_line_tracker #(
        .LINE_BYTES (LINE_BYTES)
    ) u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .evt   (evt)
    );

    ulkt_link_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (in_item_reg),
        .evt       (evt),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                res_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers hold until the next load
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op           <= s_tuser;
            in_item_reg.rx_byte      <= s_tdata[7:0];
            in_item_reg.now_ms       <= s_tdata[39:8];
            in_item_reg.poll_enabled <= s_tdata[40];
        end
        if (fire)
            res_reg <= res;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00, res_reg.send_command, res_reg.soft_off, res_reg.powered,
                       res_reg.link_state};
    assign m_tlast  = res_reg.line_ended;

    a_poweroff_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.send_command == CMD_POWER_OFF)
        |-> (res_reg.soft_off && res_reg.link_state == LINK_DOWN))
        else $error("power-off word without soft-off and link down");

    a_query_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.send_command == CMD_STATUS)
        |-> (res_reg.powered && !res_reg.soft_off && res_reg.link_state != LINK_UP))
        else $error("status query while gated");

    a_line_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.line_ended) |-> (res_reg.send_command == CMD_NONE))
        else $error("line end word carries a command");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && res_valid_reg && !m_tready))
        else $error("input stalled without output back-pressure");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("processed word produced no result");

endmodule

`default_nettype wire

### sim/tb_uart_status_line_keyword_tracker_core.sv
// Self-checking testbench for the UART status line keyword tracker core.
`timescale 1ns / 1ps

module tb_uart_status_line_keyword_tracker_core;
    import ulkt_pkg::*;

    localparam int          LINE_BYTES  = 128;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_WORDS = 115;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  rx;
        logic [31:0] now;
        logic        en;
    } uart_word_t;

    typedef struct {
        logic [1:0] link;
        logic       powered;
        logic       soft_off;
        logic       ended;
        logic [1:0] cmd;
    } line_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [21:0] cfg_data = '0;

    uart_word_t   pending_words[$];
    line_status_t expected_status[$];

    // Predicted block state
    logic [21:0]         poll_period = POLL_PERIOD_RESET;
    int                  kept_len = 0;
    int                  prefix_len[KW_COUNT] = '{default: 0};
    logic [KW_COUNT-1:0] found = '0;
    logic [1:0]          link_code = LINK_UNKNOWN;
    logic                is_powered = 1'b0;
    logic                is_soft_off = 1'b0;
    logic [31:0]         next_due = '0;

    // Stimulus bookkeeping
    logic [31:0] clock_ms = '0;
    int          queued_words = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic        word_accepted = 1'b0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          recv_calm = 0;

    uart_status_line_keyword_tracker_core #(.LINE_BYTES(LINE_BYTES)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string what);
        // hold the log to a readable size
        if (mismatch_count < 100)
            $display("MISMATCH at cycle %0d: %0s", cycle_count, what);
        mismatch_count++;
    endtask

    // Longest keyword prefix that ends the matched text followed by byte c
    function automatic int next_match(input int k, input int p, input logic [7:0] c);
        logic [7:0] hist [KW_MAX+1];
        int         len;
        int         top;
        bit         hit;
        len = KW_LEN[k];
        if (p >= len)
            p = 0;
        top = (p + 1 < len) ? p + 1 : len;
        for (int i = 0; i < p; i++)
            hist[i] = KW_TEXT[k][i];
        hist[p] = c;
        for (int n = top; n > 0; n--)
        begin
            hit = 1'b1;
            for (int j = 0; j < n; j++)
                if (hist[p + 1 - n + j] != KW_TEXT[k][j])
                    hit = 1'b0;
            if (hit)
                return n;
        end
        return 0;
    endfunction

    task automatic track_word(input logic [1:0] op, input logic [7:0] c,
                              input logic [31:0] now, input logic en,
                              output line_status_t r);
        logic [31:0] due;
        logic [31:0] lag;
        int          n;
        r.ended = 1'b0;
        r.cmd   = CMD_NONE;
        case (op)
            OP_RX_BYTE:
            begin
                if (c == CHAR_NEWLINE)
                begin
                    if (kept_len != 0)
                    begin
                        if (found[KW_POWER_ON])
                        begin
                            is_powered  = 1'b1;
                            is_soft_off = 1'b0;
                            link_code   = LINK_UNKNOWN;
                        end
                        if (found[KW_DISCONNECT] || found[KW_STATUS0])
                            link_code = LINK_DOWN;
                        else if (found[KW_CONNECT] || found[KW_STATUS1])
                            link_code = LINK_UP;
                        else if (found[KW_SCAN])
                            link_code = LINK_SCAN;
                        kept_len = 0;
                        found    = '0;
                        foreach (prefix_len[k])
                            prefix_len[k] = 0;
                        r.ended = 1'b1;
                    end
                end
                else if (c >= CHAR_PRINTABLE && kept_len < LINE_BYTES - 1)
                begin
                    kept_len++;
                    for (int k = 0; k < KW_COUNT; k++)
                    begin
                        n = next_match(k, prefix_len[k], c);
                        if (n == int'(KW_LEN[k]))
                        begin
                            found[k] = 1'b1;
                            n = 0;
                        end
                        prefix_len[k] = n;
                    end
                end
            end
            OP_TICK:
            begin
                due = now + 32'(poll_period);
                lag = now - next_due;
                if (!en || !is_powered || is_soft_off || link_code == LINK_UP)
                    next_due = due;
                else if (!lag[31])
                begin
                    next_due = due;
                    r.cmd    = CMD_STATUS;
                end
            end
            OP_POWER_OFF:
            begin
                r.cmd       = CMD_POWER_OFF;
                is_soft_off = 1'b1;
                link_code   = LINK_DOWN;
            end
            default: ;
        endcase
        r.link     = link_code;
        r.powered  = is_powered;
        r.soft_off = is_soft_off;
    endtask

    // Mostly short gaps, some long ones, and now and then a calm stretch with none
    task automatic draw_gap(inout int calm, output int gap);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else if (r < 5)
        begin
            calm = $urandom_range(20, 80);
            gap  = 0;
        end
        else if (r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
    endtask

    // Driver: change inputs at the falling edge
    always @(negedge clk)
    begin
        uart_word_t w;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !word_accepted)
            ;   // hold the word until taken
        else if (send_gap > 0)
        begin
            s_tvalid <= 1'b0;
            send_gap--;
        end
        else if (pending_words.size() != 0)
        begin
            w = pending_words.pop_front();
            s_tdata  <= {7'd0, w.en, w.now, w.rx};
            s_tuser  <= w.op;
            s_tvalid <= 1'b1;
            draw_gap(send_calm, send_gap);
        end
        else
            s_tvalid <= 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            draw_gap(recv_calm, stall_left);
        end
    end

    // Monitor: predict on accepted input words, check accepted result words
    always @(posedge clk)
    begin
        line_status_t r;
        line_status_t e;
        if (rst_n)
        begin
            word_accepted <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                track_word(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[40], r);
                expected_status.push_back(r);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_status.size() == 0)
                    note_mismatch("result word with no expectation waiting");
                else
                begin
                    e = expected_status.pop_front();
                    if (m_tdata[1:0] != e.link)
                        note_mismatch($sformatf("link_state got %0d exp %0d",
                                                m_tdata[1:0], e.link));
                    if (m_tdata[2] != e.powered)
                        note_mismatch($sformatf("powered got %0b exp %0b",
                                                m_tdata[2], e.powered));
                    if (m_tdata[3] != e.soft_off)
                        note_mismatch($sformatf("soft_off got %0b exp %0b",
                                                m_tdata[3], e.soft_off));
                    if (m_tlast !== e.ended)
                        note_mismatch($sformatf("line_ended got %0b exp %0b",
                                                m_tlast, e.ended));
                    if (m_tdata[5:4] != e.cmd)
                        note_mismatch($sformatf("send_command got %0d exp %0d",
                                                m_tdata[5:4], e.cmd));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_word(input logic [1:0] op, input logic [7:0] rx,
                              input logic [31:0] now, input logic en);
        uart_word_t w;
        w.op  = op;
        w.rx  = rx;
        w.now = now;
        w.en  = en;
        pending_words.push_back(w);
        if (op != OP_UNUSED)
            queued_words++;
    endtask

    task automatic queue_byte(input logic [7:0] c);
        queue_word(OP_RX_BYTE, c, $urandom, 1'($urandom));
    endtask

    // Emit a keyword, optionally split by a byte that gets dropped
    task automatic queue_keyword(input int k, input bit split);
        int cut;
        cut = $urandom_range(1, int'(KW_LEN[k]) - 1);
        for (int i = 0; i < int'(KW_LEN[k]); i++)
        begin
            if (split && i == cut)
                queue_byte(($urandom_range(0, 1) != 0) ? CHAR_CR : 8'($urandom_range(0, 9)));
            queue_byte(KW_TEXT[k][i]);
        end
    endtask

    task automatic queue_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            clock_ms += $urandom_range(0, int'(poll_period) / 2 + 1);
        else if (r < 75)
            clock_ms += 32'(poll_period) + $urandom_range(0, 2) - 1;
        else if (r < 85)
            clock_ms -= $urandom_range(0, 50);
        else if (r < 92)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
        else
            clock_ms = $urandom;
        queue_word(OP_TICK, 8'($urandom), clock_ms, $urandom_range(0, 99) < 85);
    endtask

    task automatic queue_line();
        int  pieces;
        int  r;
        int  k;
        int  m;
        logic [7:0] c;
        // now and then overrun the line buffer
        if ($urandom_range(0, 99) < 4)
        begin
            m = $urandom_range(118, 135);
            for (int i = 0; i < m; i++)
                queue_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
        pieces = $urandom_range(0, 5);
        for (int p = 0; p < pieces; p++)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 99) < 35) ? KW_POWER_ON : $urandom_range(0, KW_COUNT - 1);
            if (r < 35)
                queue_keyword(k, $urandom_range(0, 9) == 0);
            else if (r < 45)
            begin
                m = $urandom_range(1, int'(KW_LEN[k]) - 1);
                for (int i = 0; i < m; i++)
                    queue_byte(KW_TEXT[k][i]);
            end
            else if (r < 75)
            begin
                m = $urandom_range(1, 6);
                for (int i = 0; i < m; i++)
                begin
                    k = $urandom_range(0, KW_COUNT - 1);
                    if ($urandom_range(0, 1) != 0)
                        c = KW_TEXT[k][$urandom_range(0, int'(KW_LEN[k]) - 1)];
                    else
                        c = 8'($urandom_range(8'h20, 8'h7E));
                    queue_byte(c);
                end
            end
            else if (r < 85)
            begin
                c = 8'($urandom_range(0, 8'h1F));
                queue_byte((c == CHAR_NEWLINE) ? CHAR_CR : c);
            end
            else
                queue_byte(8'($urandom_range(8'h7F, 8'hFF)));
        end
        if ($urandom_range(0, 99) < 92)
            queue_byte(CHAR_NEWLINE);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(input logic [21:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        poll_period = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [21:0] periods [6];
        int          r;
        periods = '{22'd0, 22'd1, 22'd3600000, 22'h3F_FFFF,
                    22'($urandom_range(2, 5000)), POLL_PERIOD_RESET};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: byte extremes, dropped bytes, empty line, power on, ticks, unused opcode, power off
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h7F);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_NEWLINE);
        queue_byte(CHAR_NEWLINE);
        queue_keyword(KW_POWER_ON, 1'b0);
        queue_byte(CHAR_NEWLINE);
        queue_word(OP_TICK, 8'hFF, 32'h0000_0000, 1'b1);
        queue_word(OP_TICK, 8'h00, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_TICK, 8'hA5, 32'h7FFF_FFFF, 1'b1);
        queue_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        queue_word(OP_POWER_OFF, 8'h5A, 32'h8000_0000, 1'b0);
        queue_word(OP_TICK, 8'h3C, 32'hC000_0000, 1'b1);
        drain();

        foreach (periods[p])
        begin
            write_period(periods[p]);
            queued_words = 0;
            while (queued_words < PHASE_WORDS)
            begin
                queue_line();
                r = $urandom_range(0, 99);
                if (r < 40)
                    repeat ($urandom_range(1, 3)) queue_tick();
                else if (r < 46)
                    queue_word(OP_POWER_OFF, 8'($urandom), $urandom, 1'($urandom));
                else if (r < 49)
                    queue_word(OP_UNUSED, 8'($urandom), $urandom, 1'($urandom));
            end
            // pause the sender until every result is back
            drain();
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
